FILE: hdl/srsw_pkg.sv
// shared types and codes for the selective-repeat send window
// no dependencies
`default_nettype none

package srsw_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 16;
  localparam int unsigned CNT_W            = 5;
  localparam int unsigned SEQ_W            = 32;
  localparam int unsigned HND_W            = 16;
  localparam logic [CNT_W-1:0] MAX_RESET   = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ACK    = 2'd1,
    OP_RESEND = 2'd2,
    OP_CLEAN  = 2'd3
  } op_t;

  localparam logic [1:0] ST_NOT_SENT = 2'd0;
  localparam logic [1:0] ST_RESEND   = 2'd1;
  localparam logic [1:0] ST_ACKED    = 2'd2;

  typedef struct packed {
    logic [1:0]       status;
    logic [HND_W-1:0] handle;
    logic [SEQ_W-1:0] seq;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/srsw_ram.sv
// entry store of the send window, one write and one registered read port
// depends on srsw_pkg
`default_nettype none

module srsw_ram import srsw_pkg::*; #(
  parameter int unsigned DEPTH = WINDOW_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/selective_repeat_send_window.sv
// top level of the selective-repeat send window: control sequencer and result register
// depends on srsw_pkg and srsw_ram
//
// channel | dir | fields (lsb first)
// in_     | in  | tuser: op[1:0]; tdata: seq_num[31:0], packet_handle[47:32]
// out_    | out | tdata: ok, entry_count[5:1], removed_count[10:6], next_valid[11],
//         |     |        next_seq[43:12], next_handle[59:44], zero[63:60]
// cfg_    | in  | wdata: max_entries[4:0]
//
// one beat at a time: ack, resend and clean make one pass over the entries held before
// the beat, an add first writes its entry (if there is room) and then passes over all
// held entries, each pass through the single read port of the store
// an ack or resend write-back goes to the entry just read, behind the read stream
// reset clears head, count and control; the entry store is not cleared
// a finished result sits in the output register while the next beat is taken
`default_nettype none

module selective_repeat_send_window import srsw_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // seq_num, packet_handle
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // ok, entry_count, removed_count, next_valid, next_seq,
                                  // next_handle
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_SCAN, S_DONE} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] max_r;
  logic [AW-1:0]    head_r;
  logic [CNT_W-1:0] held_r;
  op_t              op_r;
  logic [SEQ_W-1:0] seq_r;
  logic [HND_W-1:0] hnd_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] iss_r;
  logic [AW-1:0]    rd_slot_r;
  logic             dv_r;
  logic [AW-1:0]    dslot_r;
  logic             found_r;
  logic             lead_r;
  logic             ok_r;
  logic [CNT_W-1:0] rem_r;
  logic             nv_r;
  logic [SEQ_W-1:0] nseq_r;
  logic [HND_W-1:0] nh_r;
  logic             out_valid_r;
  logic [63:0]      out_data_r;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(WINDOW_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  logic          room;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_slot;
  logic          rd_en;
  entry_t        rdata;
  logic          hit;
  logic [1:0]    new_st;
  logic [1:0]    eff_st;
  logic          needy;
  logic          retire;
  logic          scan_end;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  always_comb begin
    room      = (held_r < max_r) && (SW'(held_r) < SW'(WINDOW_DEPTH));
    tail_sum  = SW'(head_r) + SW'(held_r);
    tail_slot = (tail_sum >= SW'(WINDOW_DEPTH)) ? AW'(tail_sum - SW'(WINDOW_DEPTH))
                                                : AW'(tail_sum);
    rd_en     = (state_r == S_SCAN) && (iss_r < n_r);
    hit       = dv_r && (op_r == OP_ACK || op_r == OP_RESEND) && !found_r &&
                (rdata.seq == seq_r);
    new_st    = (op_r == OP_ACK) ? ST_ACKED : ST_RESEND;
    eff_st    = hit ? new_st : rdata.status;
    needy     = eff_st inside {ST_NOT_SENT, ST_RESEND};
    retire    = dv_r && (op_r == OP_CLEAN) && lead_r && (rdata.status == ST_ACKED);
    scan_end  = (state_r == S_SCAN) && (iss_r == n_r) && !dv_r;
    if ((state_r == S_ADD) && room) begin
      we    = 1'b1;
      waddr = tail_slot;
      wdata = '{status: ST_NOT_SENT, handle: hnd_r, seq: seq_r};
    end else begin
      we    = hit;
      waddr = dslot_r;
      wdata = '{status: new_st, handle: rdata.handle, seq: rdata.seq};
    end
  end

  srsw_ram #(.DEPTH(WINDOW_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_slot_r),
    .rdata (rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= MAX_RESET;
      head_r      <= '0;
      held_r      <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r      <= op_t'(in_tuser);
            seq_r     <= in_tdata[31:0];
            hnd_r     <= in_tdata[47:32];
            ok_r      <= (op_t'(in_tuser) == OP_CLEAN);
            rem_r     <= '0;
            nv_r      <= 1'b0;
            nseq_r    <= '0;
            nh_r      <= '0;
            found_r   <= 1'b0;
            lead_r    <= 1'b1;
            iss_r     <= '0;
            rd_slot_r <= head_r;
            n_r       <= held_r;
            state_r   <= (op_t'(in_tuser) == OP_ADD) ? S_ADD : S_SCAN;
          end
        end
        S_ADD: begin
          if (room) begin
            held_r <= held_r + 1'b1;
            n_r    <= held_r + 1'b1;
            ok_r   <= 1'b1;
          end
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_en) begin
            iss_r     <= iss_r + 1'b1;
            rd_slot_r <= slot_inc(rd_slot_r);
          end
          dv_r    <= rd_en;
          dslot_r <= rd_slot_r;
          if (hit) begin
            found_r <= 1'b1;
            ok_r    <= 1'b1;
          end
          if (dv_r && !nv_r && needy) begin
            nv_r   <= 1'b1;
            nseq_r <= rdata.seq;
            nh_r   <= rdata.handle;
          end
          if (dv_r) begin
            if (retire) begin
              rem_r  <= rem_r + 1'b1;
              head_r <= slot_inc(head_r);
              held_r <= held_r - 1'b1;
            end else begin
              lead_r <= 1'b0;
            end
          end
          if (scan_end) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {4'b0000, nh_r, nseq_r, nv_r, rem_r, held_r, ok_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(held_r) <= SW'(WINDOW_DEPTH))
    else $error("held count above window depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("beat taken while another is in progress");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_r <= n_r))
    else $error("scan read past held entries");

  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[10:6] == 5'd0))
    else $error("entries retired on a failed operation");
`endif

endmodule

`default_nettype wire

FILE: test/selective_repeat_send_window_tb.sv
// self-checking testbench for selective_repeat_send_window: queued window commands,
// a transaction-level predictor of the window and a field-by-field check of every result beat
// depends on srsw_pkg and the selective_repeat_send_window rtl
module selective_repeat_send_window_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srsw_pkg::*;

  localparam int unsigned DEPTH = WINDOW_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 152;

  typedef struct {
    op_t         op;
    logic [31:0] seq;
    logic [15:0] handle;
  } window_cmd_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] next_handle;
    logic [31:0] next_seq;
    logic        next_valid;
    logic [4:0]  removed;
    logic [4:0]  count;
    logic        ok;
  } window_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  window_cmd_t    cmd_queue[$];
  window_report_t expected_reports[$];
  logic [31:0]    seq_pool[$];

  // predicted window contents
  logic [31:0] win_seq[DEPTH];
  logic [15:0] win_handle[DEPTH];
  logic [1:0]  win_status[DEPTH];
  int unsigned win_head = 0;
  int unsigned win_held = 0;
  int unsigned win_max = MAX_RESET;

  int unsigned cmds_pushed = 0;
  int unsigned cmds_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned idle_mode = 1;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 300;
  int unsigned rx_tick = 0;
  logic [31:0] rx_pattern = '1;
  int unsigned stuck_cycles = 0;
  logic [31:0] seq_ctr = 32'h0000_1000;
  int unsigned max_plan[12] = '{0, 1, 4, 31, 16, 9, 2, 16, 7, 31, 3, 16};

  selective_repeat_send_window dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // seq_num, packet_handle
    .in_tuser  (in_tuser),   // op
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // ok, entry_count, removed_count, next_valid, next_seq,
                             // next_handle
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic window_step(input op_t op, input logic [31:0] seq, input logic [15:0] hnd);
    window_report_t r;
    int unsigned slot;
    int unsigned i;
    logic hit;
    r = '0;
    hit = 1'b0;
    case (op)
      OP_ADD: begin
        if (win_held < win_max && win_held < DEPTH) begin
          slot = (win_head + win_held) % DEPTH;
          win_seq[slot] = seq;
          win_handle[slot] = hnd;
          win_status[slot] = ST_NOT_SENT;
          win_held++;
          r.ok = 1'b1;
        end
      end
      OP_ACK, OP_RESEND: begin
        for (i = 0; i < win_held; i++) begin
          slot = (win_head + i) % DEPTH;
          if (!hit && win_seq[slot] == seq) begin
            win_status[slot] = (op == OP_ACK) ? ST_ACKED : ST_RESEND;
            hit = 1'b1;
          end
        end
        r.ok = hit;
      end
      default: begin
        while (win_held > 0 && win_status[win_head] == ST_ACKED) begin
          win_head = (win_head + 1) % DEPTH;
          win_held--;
          r.removed++;
        end
        r.ok = 1'b1;
      end
    endcase
    for (i = 0; i < win_held; i++) begin
      slot = (win_head + i) % DEPTH;
      if (!r.next_valid && (win_status[slot] == ST_NOT_SENT || win_status[slot] == ST_RESEND))
      begin
        r.next_valid = 1'b1;
        r.next_seq = win_seq[slot];
        r.next_handle = win_handle[slot];
      end
    end
    r.count = win_held[4:0];
    expected_reports.push_back(r);
  endtask

  task automatic push_cmd(input op_t op, input logic [31:0] seq, input logic [15:0] hnd);
    window_cmd_t c;
    c.op = op;
    c.seq = seq;
    c.handle = hnd;
    cmd_queue.push_back(c);
    cmds_pushed++;
  endtask

  task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  function automatic logic [31:0] pool_pick();
    int unsigned idx;
    if (seq_pool.size() == 0) return $urandom;
    idx = $urandom_range(0, seq_pool.size() - 1);
    if ($urandom_range(0, 1) == 0) idx = idx / 4;
    return seq_pool[idx];
  endfunction

  task automatic gen_random(input int unsigned n);
    int unsigned add_w;
    int unsigned roll;
    int unsigned k;
    logic [31:0] s;
    add_w = $urandom_range(25, 60);
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_w) begin
        case ($urandom_range(0, 9))
          0, 1: s = $urandom;
          2: s = pool_pick();
          default: begin
            seq_ctr++;
            s = seq_ctr;
          end
        endcase
        push_cmd(OP_ADD, s, 16'($urandom));
        seq_pool.push_back(s);
        if (seq_pool.size() > 24) void'(seq_pool.pop_front());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 45) push_cmd(OP_ACK, pool_pick(), 16'($urandom));
        else if (roll < 60) push_cmd(OP_RESEND, pool_pick(), 16'($urandom));
        else if (roll < 90) push_cmd(OP_CLEAN, $urandom, 16'($urandom));
        else if (roll < 95) push_cmd(OP_ACK, $urandom, 16'($urandom));
        else push_cmd(OP_RESEND, $urandom, 16'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (cmds_accepted != cmds_pushed || expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_max(input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    win_max = v;
  endtask

  // sender
  always @(posedge clk) begin
    window_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        window_step(op_t'(in_tuser), in_tdata[31:0], in_tdata[47:32]);
        cmds_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          c = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.op;
          in_tdata <= {c.handle, c.seq};
          if (idle_mode != 0) begin
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 24);
              gap_left = (idle_mode == 2) ? $urandom_range(1, 16) : $urandom_range(1, 5);
            end
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with its own stall pattern and an occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = 400;
        next_hold_at += 900;
      end
      rx_tick = (rx_tick + 1) % 64;
      if (rx_tick == 0) rx_pattern = $urandom;
      else rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (idle_mode == 0) || rx_pattern[0] || (idle_mode == 1 && rx_pattern[1]);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    window_report_t got;
    window_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing expected: %0h", out_tdata);
        err_count++;
      end else begin
        want = expected_reports.pop_front();
        report_field("ok", want.ok, got.ok);
        report_field("entry_count", want.count, got.count);
        report_field("removed_count", want.removed, got.removed);
        report_field("next_valid", want.next_valid, got.next_valid);
        report_field("next_seq", want.next_seq, got.next_seq);
        report_field("next_handle", want.next_handle, got.next_handle);
        report_field("pad", want.pad, got.pad);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset maximum, empty-window cases, duplicates, no match, clean, full window
    push_cmd(OP_CLEAN, 32'h1234_5678, 16'hABCD);
    push_cmd(OP_ACK, 32'h0, 16'h0);
    push_cmd(OP_ADD, 32'h0, 16'h0);
    push_cmd(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    push_cmd(OP_ADD, 32'h0, 16'h1234);
    push_cmd(OP_ACK, 32'h0, 16'hFFFF);
    push_cmd(OP_RESEND, 32'hFFFF_FFFF, 16'h0);
    push_cmd(OP_ACK, 32'h0, 16'h0);
    push_cmd(OP_ACK, 32'h5, 16'h0);
    push_cmd(OP_RESEND, 32'h5, 16'h0);
    push_cmd(OP_CLEAN, 32'h0, 16'h0);
    push_cmd(OP_CLEAN, 32'hFFFF_FFFF, 16'hFFFF);
    for (k = 0; k < 14; k++) push_cmd(OP_ADD, 32'h100 + k, 16'(k));
    push_cmd(OP_ADD, 32'hDEAD_BEEF, 16'h5555);

    for (p = 0; p < 12; p++) begin
      wait_drained();
      repeat (30) @(posedge clk);
      write_max(max_plan[p]);
      idle_mode = p % 3;
      if (p == 3) seq_ctr = 32'hFFFF_FFF0;
      gen_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
